// ----- sv/cdr_pkg.sv -----
// Shared types and constants for the checked signed divider.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package cdr_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int STATUS_W       = 2;

	typedef enum logic {
		OP_QUOT = 1'b0,
		OP_REM  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// per-request control that rides along the cell chain
	typedef struct packed {
		op_t     op;
		logic    neg_q;
		logic    neg_r;
		status_t status;
	} ctl_t;

endpackage

// ----- sv/cdr_cell.sv -----
// One restoring-division cell: produces one quotient bit per request and
// registers the partial remainder for the next cell. Depends on cdr_pkg.
`timescale 1ns / 1ps

module cdr_cell #(
	parameter int DATA_WIDTH = cdr_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] in_rem,
	input  logic [DATA_WIDTH-1:0] in_quo,
	input  logic [DATA_WIDTH-1:0] in_den,
	input  cdr_pkg::ctl_t         in_ctl,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_rem,
	output logic [DATA_WIDTH-1:0] out_quo,
	output logic [DATA_WIDTH-1:0] out_den,
	output cdr_pkg::ctl_t         out_ctl
);
	import cdr_pkg::*;

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH+1:0] diff;
	logic                  ge;
	logic [DATA_WIDTH-1:0] rem_nx;
	logic [DATA_WIDTH-1:0] quo_nx;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] den_q;
	ctl_t                  ctl_q;

	// shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		trial  = {in_rem, in_quo[DATA_WIDTH-1]};
		diff   = {1'b0, trial} - {2'b00, in_den};
		ge     = ~diff[DATA_WIDTH+1];
		rem_nx = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		quo_nx = {in_quo[DATA_WIDTH-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			den_q <= in_den;
			ctl_q <= in_ctl;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_quo   = quo_q;
	assign out_den   = den_q;
	assign out_ctl   = ctl_q;

endmodule

// ----- sv/cdr_out.sv -----
// Output stage: sign fixup, error zeroing, and an output register with a
// skid entry so the cell chain can keep moving. Depends on cdr_pkg.
`timescale 1ns / 1ps

module cdr_out #(
	parameter int DATA_WIDTH = cdr_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [DATA_WIDTH-1:0]                 in_rem,
	input  logic [DATA_WIDTH-1:0]                 in_quo,
	input  cdr_pkg::ctl_t                         in_ctl,
	output logic                                  adv,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata,  // value, zero padded
	output logic [cdr_pkg::STATUS_W-1:0]          m_tuser   // status
);
	import cdr_pkg::*;

	logic [DATA_WIDTH-1:0] sel;
	logic                  neg;
	logic [DATA_WIDTH-1:0] val;
	logic                  take;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_val_q;
	status_t               out_st_q;
	logic                  skid_valid_q;
	logic [DATA_WIDTH-1:0] skid_val_q;
	status_t               skid_st_q;

	always_comb begin
		sel = (in_ctl.op == OP_REM) ? in_rem : in_quo;
		neg = (in_ctl.op == OP_REM) ? in_ctl.neg_r : in_ctl.neg_q;
		if (in_ctl.status != ST_OK) begin
			val = '0;
		end else if (neg) begin
			val = '0 - sel;
		end else begin
			val = sel;
		end
	end

	assign adv  = ~skid_valid_q;
	assign take = in_valid & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= take;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_val_q <= skid_val_q;
				out_st_q  <= skid_st_q;
			end
		end else if (!out_valid_q || m_tready) begin
			out_val_q <= val;
			out_st_q  <= in_ctl.status;
		end else begin
			skid_val_q <= val;
			skid_st_q  <= in_ctl.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ((DATA_WIDTH+7)/8*8)'(out_val_q);
	assign m_tuser  = out_st_q;

endmodule

// ----- sv/checked_signed_divide_remainder.sv -----
// Checked signed divider, quotient or remainder as in C (truncate toward
// zero, remainder takes the dividend's sign). Takes one request per cycle
// while s_tready is high and returns results in order through its stages:
// one input stage that takes magnitudes and checks for a zero divisor
// or the most negative value over minus one, a chain of DATA_WIDTH cells that
// each produce one quotient bit, and an output register. A two-entry output
// buffer absorbs a stalled sink; s_tready drops only while both entries are
// full. Errors return status with a zero value. Depends on cdr_pkg, cdr_cell,
// cdr_out.
`timescale 1ns / 1ps

module checked_signed_divide_remainder #(
	parameter int DATA_WIDTH = cdr_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,  // dividend, divisor
	input  logic                                s_tuser,  // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,  // value
	output logic [cdr_pkg::STATUS_W-1:0]        m_tuser   // status
);
	import cdr_pkg::*;

	localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic                  adv;
	logic [DATA_WIDTH-1:0] dividend;
	logic [DATA_WIDTH-1:0] divisor;
	logic                  num_neg;
	logic                  den_neg;
	ctl_t                  ctl_in;

	logic                  vld_s1;
	logic [DATA_WIDTH-1:0] num_s1;
	logic [DATA_WIDTH-1:0] den_s1;
	ctl_t                  ctl_s1;

	logic                  vld_w [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_w [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_w [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] den_w [DATA_WIDTH+1];
	ctl_t                  ctl_w [DATA_WIDTH+1];

	assign dividend = s_tdata[DATA_WIDTH-1:0];
	assign divisor  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign num_neg  = dividend[DATA_WIDTH-1];
	assign den_neg  = divisor[DATA_WIDTH-1];
	assign s_tready = adv;

	always_comb begin
		ctl_in.op    = op_t'(s_tuser);
		ctl_in.neg_q = num_neg ^ den_neg;
		ctl_in.neg_r = num_neg;
		if (divisor == '0) begin
			ctl_in.status = ST_DIV_ZERO;
		end else if (dividend == MIN_VAL && divisor == '1) begin
			ctl_in.status = ST_OVERFLOW;
		end else begin
			ctl_in.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	// magnitude of the most negative value is the top bit alone, fits unsigned
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num_neg ? '0 - dividend : dividend;
			den_s1 <= den_neg ? '0 - divisor : divisor;
			ctl_s1 <= ctl_in;
		end
	end

	assign vld_w[0] = vld_s1;
	assign rem_w[0] = '0;
	assign quo_w[0] = num_s1;
	assign den_w[0] = den_s1;
	assign ctl_w[0] = ctl_s1;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		cdr_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (vld_w[i]),
			.in_rem   (rem_w[i]),
			.in_quo   (quo_w[i]),
			.in_den   (den_w[i]),
			.in_ctl   (ctl_w[i]),
			.out_valid(vld_w[i+1]),
			.out_rem  (rem_w[i+1]),
			.out_quo  (quo_w[i+1]),
			.out_den  (den_w[i+1]),
			.out_ctl  (ctl_w[i+1])
		);
	end

	cdr_out #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(vld_w[DATA_WIDTH]),
		.in_rem  (rem_w[DATA_WIDTH]),
		.in_quo  (quo_w[DATA_WIDTH]),
		.in_ctl  (ctl_w[DATA_WIDTH]),
		.adv     (adv),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`ifndef SYNTH
	// an error result always carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("error result with nonzero value");

	// input side stalls only behind a full output buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// final partial remainder is below the divisor magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_w[DATA_WIDTH] && ctl_w[DATA_WIDTH].status == ST_OK
		|-> rem_w[DATA_WIDTH] < den_w[DATA_WIDTH])
		else $error("remainder not below divisor");
`endif

endmodule
